// ===== hdl/snas_pkg.sv =====
// ----------------------------------------------------------------------------
// snas_pkg
// Shared types and constants of the SPI NOR access splitter.
// ----------------------------------------------------------------------------
package snas_pkg;

  localparam int ADDR_W = 24;
  localparam int LEN_W = 14;

  localparam int PAGE_BYTES = 256;
  localparam int SECTOR_BYTES = 4096;
  localparam int MAX_BYTES = 8192;
  localparam int OUT_LIMIT = 34;

  localparam int PAGE_BITS = $clog2(PAGE_BYTES);
  localparam int SEC_BITS = $clog2(SECTOR_BYTES);
  localparam int CNT_W = $clog2(OUT_LIMIT);
  localparam int CMP_W = (LEN_W > SEC_BITS + 1) ? LEN_W : SEC_BITS + 1;

  localparam logic [PAGE_BITS:0] PAGE_SIZE = (PAGE_BITS + 1)'(PAGE_BYTES);
  localparam logic [SEC_BITS:0] SECTOR_SIZE = (SEC_BITS + 1)'(SECTOR_BYTES);
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_BYTES);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(OUT_LIMIT - 1);

  localparam logic [1:0] KIND_READ = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_ERASE = 2'd2;

  localparam logic [7:0] OP_NONE = 8'h00;
  localparam logic [7:0] OP_READ = 8'h03;
  localparam logic [7:0] OP_PROGRAM = 8'h02;
  localparam logic [7:0] OP_ERASE = 8'h20;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NONE = 2'd1;
  localparam logic [1:0] ST_REJECT = 2'd2;

  typedef enum logic [2:0] {
    M_NONE,
    M_REJECT,
    M_READ,
    M_WRITE,
    M_ERASE
  } mode_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [ADDR_W-1:0] start_address;
    logic [LEN_W-1:0]  byte_length;
  } req_t;

  typedef struct packed {
    logic [7:0]        opcode;
    logic [ADDR_W-1:0] command_address;
    logic [LEN_W-1:0]  chunk_bytes;
    logic [1:0]        status;
    logic              last;
  } res_t;

  typedef struct packed {
    logic load;
    logic step;
  } dp_cmd_t;

  typedef struct packed {
    logic last;
  } dp_stat_t;

endpackage

// ===== hdl/snas_dp.sv =====
// ----------------------------------------------------------------------------
// snas_dp
// Datapath: request registers, page/sector chunking and result register.
// ----------------------------------------------------------------------------
module snas_dp (
  input  logic              clk,
  input  snas_pkg::dp_cmd_t cmd,
  input  snas_pkg::req_t    request,
  output snas_pkg::dp_stat_t stat,
  output snas_pkg::res_t    result
);
  import snas_pkg::*;

  mode_t             mode;
  mode_t             mode_next;
  logic [ADDR_W-1:0] addr;
  logic [LEN_W-1:0]  rem;
  logic [CNT_W-1:0]  cnt;
  res_t              res;
  res_t              res_next;

  logic [PAGE_BITS:0] room_p;
  logic [SEC_BITS:0]  room_s;
  logic [CMP_W-1:0]   rem_x;
  logic [CMP_W-1:0]   room_px;
  logic [CMP_W-1:0]   room_sx;
  logic [CMP_W-1:0]   take_p;
  logic [CMP_W-1:0]   take_s;
  logic               at_limit;
  logic [ADDR_W-1:0]  addr_next;
  logic [LEN_W-1:0]   rem_next;

  always_comb begin
    if (request.kind != KIND_READ && request.kind != KIND_WRITE &&
        request.kind != KIND_ERASE) begin
      mode_next = M_NONE;
    end else if (request.byte_length > MAX_LEN) begin
      mode_next = M_REJECT;
    end else if (request.kind == KIND_READ) begin
      mode_next = M_READ;
    end else if (request.kind == KIND_WRITE) begin
      mode_next = M_WRITE;
    end else if (request.byte_length == '0) begin
      mode_next = M_NONE;
    end else begin
      mode_next = M_ERASE;
    end
  end

  assign room_p   = PAGE_SIZE - {1'b0, addr[PAGE_BITS-1:0]};
  assign room_s   = SECTOR_SIZE - {1'b0, addr[SEC_BITS-1:0]};
  assign rem_x    = CMP_W'(rem);
  assign room_px  = CMP_W'(room_p);
  assign room_sx  = CMP_W'(room_s);
  assign take_p   = (rem_x < room_px) ? rem_x : room_px;
  assign take_s   = (rem_x < room_sx) ? rem_x : room_sx;
  assign at_limit = (cnt == CNT_LAST);

  always_comb begin
    res_next  = '0;
    addr_next = addr;
    rem_next  = rem;
    unique case (mode)
      M_NONE: begin
        res_next.status = ST_NONE;
        res_next.last   = 1'b1;
      end
      M_REJECT: begin
        res_next.status = ST_REJECT;
        res_next.last   = 1'b1;
      end
      M_READ: begin
        res_next.opcode          = OP_READ;
        res_next.command_address = addr;
        res_next.chunk_bytes     = rem;
        res_next.status          = ST_OK;
        res_next.last            = 1'b1;
      end
      M_WRITE: begin
        res_next.opcode          = OP_PROGRAM;
        res_next.command_address = addr;
        res_next.chunk_bytes     = LEN_W'(take_p);
        res_next.status          = ST_OK;
        res_next.last            = (rem_x <= room_px) || at_limit;
        addr_next                = addr + ADDR_W'(take_p);
        rem_next                 = rem - LEN_W'(take_p);
      end
      M_ERASE: begin
        res_next.opcode          = OP_ERASE;
        res_next.command_address = addr;
        res_next.status          = ST_OK;
        res_next.last            = (rem_x <= room_sx) || at_limit;
        addr_next                = addr + ADDR_W'(room_sx);
        rem_next                 = rem - LEN_W'(take_s);
      end
      default: begin
        res_next.status = ST_NONE;
        res_next.last   = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode <= mode_next;
      addr <= request.start_address;
      rem  <= request.byte_length;
      cnt  <= '0;
    end else if (cmd.step) begin
      addr <= addr_next;
      rem  <= rem_next;
      cnt  <= cnt + CNT_W'(1);
      res  <= res_next;
    end
  end

  assign stat.last = res_next.last;
  assign result    = res;

endmodule

// ===== hdl/snas_ctrl.sv =====
// ----------------------------------------------------------------------------
// snas_ctrl
// Controller: accepts a request, steps the datapath once per command.
// ----------------------------------------------------------------------------
module snas_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  snas_pkg::dp_stat_t  stat,
  output snas_pkg::dp_cmd_t   cmd,
  output logic                busy,
  output logic                strobe
);
  import snas_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        cmd.step = 1'b1;
        if (stat.last) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= cmd.step;
    end
  end

  assign busy = (state != S_IDLE);

endmodule

// ===== hdl/spi_nor_access_splitter.sv =====
// ----------------------------------------------------------------------------
// spi_nor_access_splitter
// Turns a read/write/erase request into a run of SPI NOR commands.
// ----------------------------------------------------------------------------
//  channel  | handshake          | beat
//  request  | start & !busy      | req_t: kind, start_address, byte_length
//  result   | strobe (1 cycle)   | res_t: opcode, address, chunk, status, last
//
// A request is loaded first; the chunking step then issues one command per
// cycle, and each result and its strobe are registered before they show.
// busy falls while the last result is shown, so the next request may start.
// rst clears the controller; no result follows reset until a request.
// The receiver cannot stall: each result is valid for its strobe cycle only.
module spi_nor_access_splitter (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  snas_pkg::req_t request,
  output logic           strobe,
  output snas_pkg::res_t result
);
  import snas_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  snas_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy),
    .strobe (strobe)
  );

  snas_dp u_dp (
    .clk     (clk),
    .cmd     (cmd),
    .request (request),
    .stat    (stat),
    .result  (result)
  );

endmodule
